/* src/almp_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// almp_pkg: shared types and constants for the acceleration magnitude unit
// Widths, register indexes, controller states and the command/status bundles.
// -----------------------------------------------------------------------------
package almp_pkg;

	localparam int FRAC_BITS = 8;
	localparam int ST_W      = 16 + FRAC_BITS;          // filter state width
	localparam int DIFF_W    = ST_W + 1;                 // filter difference width
	localparam int AW        = (FRAC_BITS + 1 > 9) ? FRAC_BITS + 1 : 9;
	localparam int MB_W      = (AW + 1 > 16) ? AW + 1 : 16;
	localparam int P_W       = DIFF_W + MB_W;            // multiplier product width
	localparam int ROOT_STEPS = 16;
	localparam int STEP_W    = $clog2(ROOT_STEPS);

	localparam logic [AW-1:0] ALPHA_ONE = AW'(1) << FRAC_BITS;

	localparam logic [7:0] REG_ALPHA     = 8'd0;
	localparam logic [7:0] REG_MAX_FAILS = 8'd1;

	localparam logic KIND_GOOD = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_LON,
		S_ADD_LON,
		S_MUL_LAT,
		S_ADD_LAT,
		S_SQ_LAT,
		S_SQ_LON,
		S_SUM,
		S_ROOT,
		S_FIN,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		MS_LON,
		MS_LAT,
		MS_SQ_LAT,
		MS_SQ_LON
	} mul_sel_t;

	typedef struct packed {
		logic              accept;
		logic              mul_en;
		mul_sel_t          mul_sel;
		logic              add_lon;
		logic              add_lat;
		logic              acc_load;
		logic              rad_load;
		logic              root_step;
		logic [STEP_W-1:0] root_idx;
		logic              mag_load;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic online;
	} sts_t;

endpackage

/* src/almp_ctrl.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// almp_ctrl: sequencer for the acceleration magnitude unit
// Walks one item through filter, square, root and output hand-off.
// -----------------------------------------------------------------------------
module almp_ctrl import almp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_kind,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              take;

	assign in_ready  = (state_q == S_IDLE);
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					if (sts.online && in_kind == KIND_GOOD) state_d = S_MUL_LON;
					else state_d = S_DONE;
				end
			end
			S_MUL_LON: state_d = S_ADD_LON;
			S_ADD_LON: state_d = S_MUL_LAT;
			S_MUL_LAT: state_d = S_ADD_LAT;
			S_ADD_LAT: state_d = S_SQ_LAT;
			S_SQ_LAT:  state_d = S_SQ_LON;
			S_SQ_LON:  state_d = S_SUM;
			S_SUM:     state_d = S_ROOT;
			S_ROOT: begin
				if (step_q == STEP_W'(ROOT_STEPS - 1)) state_d = S_FIN;
			end
			S_FIN:     state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.accept    = take;
		cmd.mul_sel   = MS_LON;
		cmd.root_idx  = step_q;
		unique case (state_q)
			S_MUL_LON: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_LON;
			end
			S_ADD_LON: cmd.add_lon = 1'b1;
			S_MUL_LAT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_LAT;
			end
			S_ADD_LAT: cmd.add_lat = 1'b1;
			S_SQ_LAT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_SQ_LAT;
			end
			S_SQ_LON: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MS_SQ_LON;
				cmd.acc_load = 1'b1;
			end
			S_SUM:  cmd.rad_load  = 1'b1;
			S_ROOT: cmd.root_step = 1'b1;
			S_FIN:  cmd.mag_load  = 1'b1;
			S_DONE: cmd.out_load  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ROOT) step_q <= step_q + STEP_W'(1);
			else step_q <= '0;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_root_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROOT && step_q == STEP_W'(ROOT_STEPS - 1) |=> state_q == S_FIN)
		else $error("root iteration did not end after the last step");

	a_done_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && !out_ready |=> state_q == S_DONE)
		else $error("result left done state while output slot was full");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("output valid dropped before its transfer");

endmodule

/* src/almp_dp.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// almp_dp: datapath of the acceleration magnitude unit
// Filter states, shared multiplier, bit-serial square root, peak and fail count.
// -----------------------------------------------------------------------------
module almp_dp import almp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        in_kind,
	input  logic [15:0] in_lon,
	input  logic [15:0] in_lat,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output logic [63:0] out_data,
	output logic [1:0]  out_flags
);

	logic [8:0]              alpha_q;
	logic [7:0]              max_fails_q;
	logic [7:0]              fc_q;
	logic                    online_q;
	logic                    upd_q;
	logic signed [15:0]      x_lon_q, x_lat_q;
	logic signed [ST_W-1:0]  lon_st_q, lat_st_q;
	logic signed [P_W-1:0]   mul_q;
	logic [31:0]             acc_q, rad_q, root_q;
	logic [15:0]             mag_q, peak_q;
	logic [63:0]             out_data_q;
	logic [1:0]              out_flags_q;

	logic [AW-1:0]           a_clamp;
	logic signed [DIFF_W-1:0] diff_lon, diff_lat, mul_a;
	logic signed [MB_W-1:0]  mul_b, a_s;
	logic signed [P_W-1:0]   prod;
	logic signed [ST_W-1:0]  inc;
	logic signed [15:0]      lon_i, lat_i;
	logic [31:0]             bit_w, trial;
	logic [7:0]              fc_inc;

	assign sts.online = online_q;

	assign a_clamp = (AW'(alpha_q) > ALPHA_ONE) ? ALPHA_ONE : AW'(alpha_q);
	assign a_s     = MB_W'($signed({1'b0, a_clamp}));

	assign diff_lon = DIFF_W'($signed({x_lon_q, {FRAC_BITS{1'b0}}})) - DIFF_W'(lon_st_q);
	assign diff_lat = DIFF_W'($signed({x_lat_q, {FRAC_BITS{1'b0}}})) - DIFF_W'(lat_st_q);

	assign lon_i = lon_st_q[ST_W-1:FRAC_BITS];
	assign lat_i = lat_st_q[ST_W-1:FRAC_BITS];

	always_comb begin
		case (cmd.mul_sel)
			MS_LON: begin
				mul_a = diff_lon;
				mul_b = a_s;
			end
			MS_LAT: begin
				mul_a = diff_lat;
				mul_b = a_s;
			end
			MS_SQ_LAT: begin
				mul_a = DIFF_W'(lat_i);
				mul_b = MB_W'(lat_i);
			end
			default: begin
				mul_a = DIFF_W'(lon_i);
				mul_b = MB_W'(lon_i);
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	// floor of product / 2^FRAC_BITS; magnitude never exceeds the difference
	assign inc  = ST_W'(mul_q >>> FRAC_BITS);

	assign bit_w = 32'h4000_0000 >> {cmd.root_idx, 1'b0};
	assign trial = root_q + bit_w;

	assign fc_inc = (fc_q == 8'hFF) ? fc_q : fc_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= 9'd26;
			max_fails_q <= 8'd5;
			fc_q        <= '0;
			online_q    <= 1'b1;
			upd_q       <= 1'b0;
			lon_st_q    <= '0;
			lat_st_q    <= '0;
			mag_q       <= '0;
			peak_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ALPHA:     alpha_q     <= cfg_data;
					REG_MAX_FAILS: max_fails_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				upd_q <= online_q && in_kind == KIND_GOOD;
				if (online_q) begin
					if (in_kind == KIND_GOOD) begin
						fc_q <= '0;
					end else begin
						fc_q <= fc_inc;
						if (fc_inc >= max_fails_q) online_q <= 1'b0;
					end
				end
			end
			if (cmd.add_lon) lon_st_q <= lon_st_q + inc;
			if (cmd.add_lat) lat_st_q <= lat_st_q + inc;
			if (cmd.mag_load) begin
				mag_q <= root_q[15:0];
				if (root_q[15:0] > peak_q) peak_q <= root_q[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_lon_q <= in_lon;
			x_lat_q <= in_lat;
		end
		if (cmd.mul_en) mul_q <= prod;
		if (cmd.acc_load) acc_q <= mul_q[31:0];
		if (cmd.rad_load) begin
			rad_q  <= acc_q + mul_q[31:0];
			root_q <= '0;
		end else if (cmd.root_step) begin
			if (rad_q >= trial) begin
				rad_q  <= rad_q - trial;
				root_q <= (root_q >> 1) + bit_w;
			end else begin
				root_q <= root_q >> 1;
			end
		end
		if (cmd.out_load) begin
			out_data_q  <= {peak_q, mag_q, lon_i, lat_i};
			out_flags_q <= {upd_q, online_q};
		end
	end

	assign out_data  = out_data_q;
	assign out_flags = out_flags_q;

	a_online_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(online_q))
		else $error("unit came back online without reset");

	a_peak_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mag_load |=> peak_q >= mag_q)
		else $error("peak fell below latest magnitude");

	a_offline_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !online_q |=> fc_q == $past(fc_q) && !upd_q)
		else $error("offline item changed fail count or marked update");

endmodule

/* src/accel_lowpass_magnitude_peak_unit.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// accel_lowpass_magnitude_peak_unit: filtered acceleration magnitude with peak
// Low-pass filters two accelerometer axes, takes the vector magnitude and
// holds its peak; counts failed reads and drops offline at a set limit.
//
// Input stream: s_tdata = {raw_lat, raw_lon}, s_tuser = kind (1 = failed read).
// Output stream: one transfer per input transfer, m_tdata holds the filtered
// axes, magnitude and peak, m_tuser holds {updated, online}.
// Config channel: cfg_index 0 = alpha (1/256 units), 1 = max_fails; write
// only while no item is in flight.
//
// Sequence: a good sample runs from input transfer to output valid through
// two filter multiply/add steps, squaring of both axes, a sum, a
// bit-serial square root of ROOT_STEPS steps and a result load. A failed
// read or offline item goes straight to the result load. One item is in
// flight at a time; s_tready is high only when the sequencer is idle, so
// no new item is taken until the last one has been loaded for output.
// The finished result sits in an output register; if the receiver stalls,
// the next item still runs and waits at its end until that register frees.
// Reset restores alpha 26, max_fails 5, zero filters and peak, online.
// -----------------------------------------------------------------------------
module accel_lowpass_magnitude_peak_unit import almp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [15:0] raw_lon, [31:16] raw_lat
	input  logic        s_tuser,    // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // [15:0] lat_filtered, [31:16] lon_filtered,
	                                // [47:32] total_mag, [63:48] peak_mag
	output logic [1:0]  m_tuser,    // [0] online, [1] updated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	almp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	almp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_kind   (s_tuser),
		.in_lon    (s_tdata[15:0]),
		.in_lat    (s_tdata[31:16]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_tdata),
		.out_flags (m_tuser)
	);

endmodule

/* tb/accel_lowpass_magnitude_peak_unit_tb.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// accel_lowpass_magnitude_peak_unit_tb: self-checking bench for the magnitude unit
// Drives good samples and failed reads through the input stream with random
// gaps and output stalls. It predicts each output transfer from its own copy
// of the axis filters, peak hold and failure counter, and compares every
// field. It sweeps alpha and max_fails between phases, holds off the
// receiver long enough to block the input, and ends with the unit offline.
// -----------------------------------------------------------------------------
module accel_lowpass_magnitude_peak_unit_tb;
	import almp_pkg::*;

	localparam int          CYCLE_LIMIT = 500_000;
	localparam int          UNITY       = 1 << FRAC_BITS;
	localparam logic        KIND_FAILED = 1'b1;
	localparam logic [7:0]  REG_SPARE   = 8'hFF;

	typedef struct packed {
		logic [15:0] lat_f;
		logic [15:0] lon_f;
		logic [15:0] total;
		logic [15:0] peak;
		logic        online;
		logic        updated;
	} mag_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [8:0]  cfg_data  = '0;

	// predictor state, mirrors the reset values of the unit
	logic [8:0]              alpha_set  = 9'd26;
	logic [7:0]              fail_limit = 8'd5;
	logic signed [ST_W-1:0]  lat_acc    = '0;
	logic signed [ST_W-1:0]  lon_acc    = '0;
	logic [15:0]             peak_hold  = '0;
	logic [7:0]              fail_run   = '0;
	logic                    link_up    = 1'b1;

	mag_result_t pending_q[$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          hold_cycles    = 0;
	bit          steady_flow    = 1'b0;

	accel_lowpass_magnitude_peak_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
			pending_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic signed [ST_W-1:0] ema_update(input logic signed [ST_W-1:0] acc,
			input logic signed [15:0] sample, input int weight);
		longint gap;
		gap = (longint'(sample) <<< FRAC_BITS) - longint'(acc);
		return ST_W'(longint'(acc) + ((longint'(weight) * gap) >>> FRAC_BITS));
	endfunction

	function automatic logic [15:0] floor_root(input logic [31:0] value);
		logic [33:0] rem;
		logic [33:0] root;
		logic [33:0] bit_w;
		rem   = {2'b00, value};
		root  = '0;
		bit_w = 34'h1_0000_0000;
		while (bit_w > rem)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (rem >= root + bit_w) begin
				rem  = rem - (root + bit_w);
				root = (root >> 1) + bit_w;
			end else begin
				root = root >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return root[15:0];
	endfunction

	function automatic mag_result_t filter_and_measure(input logic kind,
			input logic signed [15:0] lon, input logic signed [15:0] lat);
		mag_result_t       r;
		int                weight;
		logic signed [15:0] lat_i;
		logic signed [15:0] lon_i;
		longint            sum_sq;
		r.updated = 1'b0;
		if (link_up) begin
			if (kind == KIND_GOOD) begin
				weight   = (int'(alpha_set) > UNITY) ? UNITY : int'(alpha_set);
				fail_run = '0;
				lon_acc  = ema_update(lon_acc, lon, weight);
				lat_acc  = ema_update(lat_acc, lat, weight);
				r.updated = 1'b1;
			end else begin
				if (fail_run != 8'hFF)
					fail_run = fail_run + 8'd1;
				if (fail_run >= fail_limit)
					link_up = 1'b0;
			end
		end
		lat_i  = 16'(lat_acc >>> FRAC_BITS);
		lon_i  = 16'(lon_acc >>> FRAC_BITS);
		sum_sq = longint'(lat_i) * lat_i + longint'(lon_i) * lon_i;
		r.total = floor_root(32'(sum_sq));
		if (r.updated && r.total > peak_hold)
			peak_hold = r.total;
		r.lat_f  = lat_i;
		r.lon_f  = lon_i;
		r.peak   = peak_hold;
		r.online = link_up;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what);
		$display("ERROR cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%h want 0x%h", name, got, want));
	endtask

	task automatic check_result(input logic [63:0] data, input logic [1:0] user);
		mag_result_t want;
		if (pending_q.size() == 0) begin
			report_mismatch($sformatf("output transfer with nothing predicted, data 0x%h", data));
		end else begin
			want = pending_q.pop_front();
			compare_field("lat_filtered", data[15:0], want.lat_f);
			compare_field("lon_filtered", data[31:16], want.lon_f);
			compare_field("total_mag", data[47:32], want.total);
			compare_field("peak_mag", data[63:48], want.peak);
			compare_field("online", {15'd0, user[0]}, {15'd0, want.online});
			compare_field("updated", {15'd0, user[1]}, {15'd0, want.updated});
		end
	endtask

	initial begin : result_monitor
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_result(m_tdata, m_tuser);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (!steady_flow && stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 6);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_item(input logic kind, input logic [15:0] lon, input logic [15:0] lat);
		if (!steady_flow && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {lat, lon};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		pending_q.push_back(filter_and_measure(kind, lon, lat));
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [8:0] val);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ALPHA:     alpha_set  = val;
			REG_MAX_FAILS: fail_limit = val[7:0];
			default: ;
		endcase
	endtask

	function automatic logic [15:0] pick_count();
		case ($urandom_range(0, 5))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'(int'($urandom_range(0, 600)) - 300);
			default: return 16'($urandom);
		endcase
	endfunction

	// fail bursts stay below the limit and are always closed by a good sample
	task automatic run_mixed_items(input int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 8);
				repeat (burst) send_item(KIND_FAILED, 16'($urandom), 16'($urandom));
				sent += burst;
			end
			send_item(KIND_GOOD, pick_count(), pick_count());
			sent++;
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_reset_defaults();
		send_item(KIND_GOOD, 16'd1000, -16'sd1000);
		send_item(KIND_GOOD, 16'h7FFF, 16'h8000);
		send_item(KIND_FAILED, 16'h8000, 16'h7FFF);
	endtask

	task automatic test_field_extremes();
		// alpha of one: filters track the input exactly
		write_reg(REG_ALPHA, 9'd256);
		send_item(KIND_GOOD, 16'h8000, 16'h7FFF);
		send_item(KIND_GOOD, 16'h7FFF, 16'h8000);
		send_item(KIND_GOOD, 16'h8000, 16'h8000);
		send_item(KIND_GOOD, 16'h0000, 16'h0000);
		// alpha above one clamps
		write_reg(REG_ALPHA, 9'h1FF);
		send_item(KIND_GOOD, 16'h7FFF, 16'h7FFF);
		send_item(KIND_GOOD, 16'h0001, 16'hFFFF);
		write_reg(REG_ALPHA, 9'd257);
		send_item(KIND_GOOD, 16'h8000, 16'h0000);
		// alpha zero: filters hold
		write_reg(REG_ALPHA, 9'd0);
		send_item(KIND_GOOD, 16'd12345, -16'sd12345);
		write_reg(REG_ALPHA, 9'd1);
		send_item(KIND_GOOD, 16'h7FFF, 16'h7FFF);
	endtask

	task automatic test_fail_counting();
		write_reg(REG_MAX_FAILS, 9'd5);
		repeat (4) send_item(KIND_FAILED, 16'($urandom), 16'($urandom));
		send_item(KIND_GOOD, 16'd300, 16'd400);
		repeat (4) send_item(KIND_FAILED, 16'($urandom), 16'($urandom));
		send_item(KIND_GOOD, -16'sd300, -16'sd400);
	endtask

	task automatic test_spare_index();
		write_reg(8'($urandom_range(2, 254)), 9'($urandom));
		write_reg(REG_SPARE, 9'h1FF);
		send_item(KIND_GOOD, 16'h7FFF, 16'h8000);
	endtask

	task automatic test_random_filtering();
		logic [8:0] alpha_list[10];
		alpha_list = '{9'd26, 9'd0, 9'd256, 9'h1FF, 9'd128, 9'd255, 9'd1, 9'h0, 9'h0, 9'h0};
		for (int p = 0; p < 10; p++) begin
			write_reg(REG_ALPHA, (p < 7) ? alpha_list[p] : 9'($urandom));
			write_reg(REG_MAX_FAILS, (p == 0) ? 9'd255 : 9'($urandom_range(9, 255)));
			run_mixed_items(140);
		end
	endtask

	task automatic test_output_backpressure();
		write_reg(REG_ALPHA, 9'($urandom_range(1, 256)));
		// stall the receiver while the sender keeps offering samples
		hold_cycles = 400;
		repeat (12) send_item(KIND_GOOD, pick_count(), pick_count());
		wait_for_results();
		run_mixed_items(30);
	endtask

	task automatic test_full_rate();
		steady_flow = 1'b1;
		write_reg(REG_ALPHA, 9'($urandom));
		write_reg(REG_MAX_FAILS, 9'($urandom_range(9, 255)));
		run_mixed_items(200);
	endtask

	task automatic test_going_offline();
		write_reg(REG_MAX_FAILS, 9'd3);
		repeat (2) send_item(KIND_FAILED, 16'($urandom), 16'($urandom));
		send_item(KIND_GOOD, pick_count(), pick_count());
		repeat (2) send_item(KIND_FAILED, 16'($urandom), 16'($urandom));
		// limit of zero: the next failed read drops the link
		write_reg(REG_MAX_FAILS, 9'd0);
		send_item(KIND_FAILED, 16'($urandom), 16'($urandom));
		repeat (20) send_item(1'($urandom), pick_count(), pick_count());
	endtask

	initial begin : main_sequence
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_fail_counting();
		test_spare_index();
		test_random_filtering();
		test_output_backpressure();
		test_full_rate();
		test_going_offline();
		wait_for_results();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
